[rtl/m3i_pkg.sv]
`timescale 1ns / 1ps

package m3i_pkg;

   // element and field widths
   localparam int IN_W      = 16;
   localparam int OUT_W     = 32;
   localparam int N_ELEM    = 9;
   localparam int PROD_W    = 2 * IN_W;          // one Q4.12 x Q4.12 product
   localparam int COF_W     = PROD_W + 1;        // difference of two products
   localparam int TRI_W     = IN_W + COF_W;      // element x cofactor
   localparam int DET_W     = TRI_W + 2;         // sum of three of them
   localparam int DEN_W     = 48;                // |det| stays below 2^48
   localparam int DV_W      = DEN_W + 1;         // 2 * |det|
   localparam int Q_SHIFT   = 28;                // Q8.24 / Q12.36 -> Q16.16
   localparam int NUM_W     = PROD_W + Q_SHIFT + 1; // 2 * |cof| * 2^28 + |det|
   localparam int QBITS     = OUT_W + 1;         // quotient bits kept
   localparam int CMP_W     = DV_W + QBITS;      // divisor at its widest shift

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [OUT_W-1:0] ONE_Q16  = OUT_W'(32'h0001_0000);
   localparam logic [OUT_W-1:0] MAX_POS  = OUT_W'(32'h7FFF_FFFF);
   localparam logic [OUT_W-1:0] MIN_NEG  = OUT_W'(32'h8000_0000);

   typedef struct packed {
      logic signed [IN_W-1:0] in_r0c0;
      logic signed [IN_W-1:0] in_r0c1;
      logic signed [IN_W-1:0] in_r0c2;
      logic signed [IN_W-1:0] in_r1c0;
      logic signed [IN_W-1:0] in_r1c1;
      logic signed [IN_W-1:0] in_r1c2;
      logic signed [IN_W-1:0] in_r2c0;
      logic signed [IN_W-1:0] in_r2c1;
      logic signed [IN_W-1:0] in_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] inv_r0c0;
      logic signed [OUT_W-1:0] inv_r0c1;
      logic signed [OUT_W-1:0] inv_r0c2;
      logic signed [OUT_W-1:0] inv_r1c0;
      logic signed [OUT_W-1:0] inv_r1c1;
      logic signed [OUT_W-1:0] inv_r1c2;
      logic signed [OUT_W-1:0] inv_r2c0;
      logic signed [OUT_W-1:0] inv_r2c1;
      logic signed [OUT_W-1:0] inv_r2c2;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

   // classified work item handed from the front to the divider
   typedef struct packed {
      logic [N_ELEM-1:0][NUM_W-1:0] num;
      logic [DV_W-1:0]              dv;
      logic [N_ELEM-1:0]            neg;
      logic [N_ELEM-1:0]            ovf;
      logic                         singular;
   } work_type;

   // one divider stage
   typedef struct packed {
      logic [N_ELEM-1:0][NUM_W-1:0] rem;
      logic [N_ELEM-1:0][QBITS-1:0] quo;
      logic [DV_W-1:0]              dv;
      logic [N_ELEM-1:0]            neg;
      logic [N_ELEM-1:0]            ovf;
      logic                         singular;
   } div_type;

   // handshake between two parts
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

[rtl/matrix3_inverse.sv]
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  req_data  (req_type, nine Q4.12)
// rsp_      out        rsp_valid / rsp_ready  rsp_data  (rsp_type, nine Q16.16 + flags)
//
// one matrix per cycle sustained while rsp_ is not stalled; a transaction reaches rsp_
// from its accepting edge through five front stages, one queue slot, 34 divider stages
// (operand load plus 33 quotient bits) and the output register
// synchronous active-high reset clears all valid flags and the queue
// a stalled rsp_ stops only the divider; the front keeps taking transactions
// until the queue between them is full

module matrix3_inverse import m3i_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // front to queue
   hs_type   push_hs;
   work_type push_data;
   // queue to divider
   hs_type   pop_hs;
   work_type pop_data;

   // cofactors, determinant and classification
   m3i_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_hs.valid),
      .push_ready (push_hs.ready),
      .push_data  (push_data)
   );

   // short decoupling queue
   m3i_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_hs    (push_hs),
      .push_ready (push_hs.ready),
      .push_data  (push_data),
      .pop_valid  (pop_hs.valid),
      .pop_hs     (pop_hs),
      .pop_data   (pop_data)
   );

   // pipelined rounding division and output register
   m3i_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_hs.valid),
      .pop_ready (pop_hs.ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // a singular matrix always comes out as the identity with no clipping
   a_singular_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         !rsp_data.saturated && rsp_data.inv_r0c0 == ONE_Q16 &&
         rsp_data.inv_r1c1 == ONE_Q16 && rsp_data.inv_r0c1 == '0)
      else $error("singular transaction without identity");

   // front may only refuse when its last stage is blocked by a full queue
   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> push_hs.valid && !push_hs.ready)
      else $error("front stalled without a full queue");

   // nothing is presented straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

[rtl/m3i_front.sv]
`timescale 1ns / 1ps

module m3i_front import m3i_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output work_type push_data
);

   logic en;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1: products
   logic signed [PROD_W-1:0] prod_ff [2*N_ELEM];
   logic signed [PROD_W-1:0] prod_in [2*N_ELEM];
   logic signed [IN_W-1:0]   a1_ff, b1_ff, c1_ff;
   // stage 2: cofactors
   logic signed [COF_W-1:0]  cof2_ff [N_ELEM];
   logic signed [IN_W-1:0]   a2_ff, b2_ff, c2_ff;
   // stage 3: expansion along row 0
   logic signed [TRI_W-1:0]  t3_ff [3];
   logic signed [COF_W-1:0]  cof3_ff [N_ELEM];
   // stage 4: determinant
   logic signed [DET_W-1:0]  det4_ff;
   logic signed [COF_W-1:0]  cof4_ff [N_ELEM];
   // stage 5: classified item
   work_type                 work5_ff, work5_in;

   assign en         = !v5_ff || push_ready;
   assign req_ready  = en;
   assign push_valid = v5_ff;
   assign push_data  = work5_ff;

   always_comb begin
      prod_in[0]  = req_data.in_r1c1 * req_data.in_r2c2;
      prod_in[1]  = req_data.in_r1c2 * req_data.in_r2c1;
      prod_in[2]  = req_data.in_r0c2 * req_data.in_r2c1;
      prod_in[3]  = req_data.in_r0c1 * req_data.in_r2c2;
      prod_in[4]  = req_data.in_r0c1 * req_data.in_r1c2;
      prod_in[5]  = req_data.in_r0c2 * req_data.in_r1c1;
      prod_in[6]  = req_data.in_r1c2 * req_data.in_r2c0;
      prod_in[7]  = req_data.in_r1c0 * req_data.in_r2c2;
      prod_in[8]  = req_data.in_r0c0 * req_data.in_r2c2;
      prod_in[9]  = req_data.in_r0c2 * req_data.in_r2c0;
      prod_in[10] = req_data.in_r0c2 * req_data.in_r1c0;
      prod_in[11] = req_data.in_r0c0 * req_data.in_r1c2;
      prod_in[12] = req_data.in_r1c0 * req_data.in_r2c1;
      prod_in[13] = req_data.in_r1c1 * req_data.in_r2c0;
      prod_in[14] = req_data.in_r0c1 * req_data.in_r2c0;
      prod_in[15] = req_data.in_r0c0 * req_data.in_r2c1;
      prod_in[16] = req_data.in_r0c0 * req_data.in_r1c1;
      prod_in[17] = req_data.in_r0c1 * req_data.in_r1c0;
   end

   // absolute values, rounding offset and overflow test
   always_comb begin
      logic signed [DET_W-1:0] adet;
      logic [DEN_W-1:0]        den;
      logic signed [COF_W-1:0] acof;
      logic [NUM_W-1:0]        nv;
      adet = det4_ff[DET_W-1] ? -det4_ff : det4_ff;
      den  = adet[DEN_W-1:0];
      work5_in          = '0;
      work5_in.dv       = {den, 1'b0};
      work5_in.singular = (det4_ff == '0);
      for (int i = 0; i < N_ELEM; i++) begin
         acof = cof4_ff[i][COF_W-1] ? -cof4_ff[i] : cof4_ff[i];
         nv   = {acof[PROD_W-1:0], {(Q_SHIFT+1){1'b0}}} + NUM_W'(den);
         work5_in.num[i] = nv;
         work5_in.neg[i] = cof4_ff[i][COF_W-1] ^ det4_ff[DET_W-1];
         work5_in.ovf[i] = CMP_W'(nv) >= {work5_in.dv, {QBITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         a1_ff   <= req_data.in_r0c0;
         b1_ff   <= req_data.in_r0c1;
         c1_ff   <= req_data.in_r0c2;
         for (int i = 0; i < N_ELEM; i++) begin
            cof2_ff[i] <= COF_W'(prod_ff[2*i]) - COF_W'(prod_ff[2*i+1]);
         end
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         c2_ff    <= c1_ff;
         t3_ff[0] <= a2_ff * cof2_ff[0];
         t3_ff[1] <= b2_ff * cof2_ff[3];
         t3_ff[2] <= c2_ff * cof2_ff[6];
         cof3_ff  <= cof2_ff;
         det4_ff  <= DET_W'(t3_ff[0]) + DET_W'(t3_ff[1]) + DET_W'(t3_ff[2]);
         cof4_ff  <= cof3_ff;
         work5_ff <= work5_in;
      end
   end

endmodule

[rtl/m3i_queue.sv]
`timescale 1ns / 1ps

module m3i_queue import m3i_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  hs_type   push_hs,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  hs_type   pop_hs,
   output work_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   work_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_hs.valid && push_ready;
   assign pop        = pop_valid && pop_hs.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/m3i_back.sv]
`timescale 1ns / 1ps

module m3i_back import m3i_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  work_type pop_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic             en;
   logic [QBITS:0]   vld_ff;
   div_type          st_ff [QBITS+1];
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[QBITS-1:0], pop_valid};
         rsp_valid_ff <= vld_ff[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].rem      <= pop_data.num;
         st_ff[0].quo      <= '0;
         st_ff[0].dv       <= pop_data.dv;
         st_ff[0].neg      <= pop_data.neg;
         st_ff[0].ovf      <= pop_data.ovf;
         st_ff[0].singular <= pop_data.singular;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      localparam int B = QBITS - 1 - k;
      logic [CMP_W-1:0]  dsh;
      logic [N_ELEM-1:0] ge;
      div_type           nxt;

      assign dsh = CMP_W'(st_ff[k].dv) << B;

      for (genvar j = 0; j < N_ELEM; j++) begin : g_elem
         assign ge[j] = CMP_W'(st_ff[k].rem[j]) >= dsh;
      end

      always_comb begin
         nxt = st_ff[k];
         for (int j = 0; j < N_ELEM; j++) begin
            if (ge[j]) begin
               nxt.rem[j] = st_ff[k].rem[j] - dsh[NUM_W-1:0];
            end
            nxt.quo[j] = {st_ff[k].quo[j][QBITS-2:0], ge[j]};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k+1] <= nxt;
         end
      end
   end

   // sign, saturation and the singular case
   always_comb begin
      logic [OUT_W-1:0]  val [N_ELEM];
      logic [N_ELEM-1:0] sat;
      logic [QBITS-1:0]  q;
      for (int i = 0; i < N_ELEM; i++) begin
         q = st_ff[QBITS].quo[i];
         if (st_ff[QBITS].neg[i]) begin
            sat[i] = st_ff[QBITS].ovf[i] || (q > {1'b0, MIN_NEG});
            val[i] = sat[i] ? MIN_NEG : -q[OUT_W-1:0];
         end else begin
            sat[i] = st_ff[QBITS].ovf[i] || (q > {1'b0, MAX_POS});
            val[i] = sat[i] ? MAX_POS : q[OUT_W-1:0];
         end
         if (st_ff[QBITS].singular) begin
            val[i] = (i % 4 == 0) ? ONE_Q16 : '0;
         end
      end
      rsp_in.inv_r0c0  = val[0];
      rsp_in.inv_r0c1  = val[1];
      rsp_in.inv_r0c2  = val[2];
      rsp_in.inv_r1c0  = val[3];
      rsp_in.inv_r1c1  = val[4];
      rsp_in.inv_r1c2  = val[5];
      rsp_in.inv_r2c0  = val[6];
      rsp_in.inv_r2c1  = val[7];
      rsp_in.inv_r2c2  = val[8];
      rsp_in.singular  = st_ff[QBITS].singular;
      rsp_in.saturated = !st_ff[QBITS].singular && (sat != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
   import m3i_pkg::*;

   // expected inverses, oldest first, and the checks against them
   class inverse_board;
      rsp_type pending[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      // cofactor * 2^28 / det, rounded half away from zero, clipped to 32 bits
      function automatic logic signed [31:0] quotient_q16(longint cof, longint det,
                                                          ref bit clipped);
         logic [127:0] num;
         logic [127:0] den;
         logic [127:0] q;
         bit           neg;
         num = (cof < 0 ? -cof : cof);
         num = num << Q_SHIFT;
         den = (det < 0 ? -det : det);
         q   = (2 * num + den) / (2 * den);
         neg = (cof < 0) != (det < 0);
         if (neg) begin
            if (q > 128'd2147483648) begin
               clipped = 1;
               return 32'sh8000_0000;
            end
            return -q[31:0];
         end
         if (q > 128'd2147483647) begin
            clipped = 1;
            return 32'sh7FFF_FFFF;
         end
         return q[31:0];
      endfunction

      // work out the inverse of one accepted matrix
      function void note_matrix(req_type m);
         longint  a, b, c, d, e, f, g, h, k, det;
         longint  cof[9];
         logic signed [31:0] el[9];
         bit      clipped;
         rsp_type r;
         a = m.in_r0c0; b = m.in_r0c1; c = m.in_r0c2;
         d = m.in_r1c0; e = m.in_r1c1; f = m.in_r1c2;
         g = m.in_r2c0; h = m.in_r2c1; k = m.in_r2c2;
         clipped = 0;
         det = a*e*k + b*f*g + c*d*h - c*e*g - a*f*h - b*d*k;
         cof[0] = e*k - f*h; cof[1] = c*h - b*k; cof[2] = b*f - c*e;
         cof[3] = f*g - d*k; cof[4] = a*k - c*g; cof[5] = c*d - a*f;
         cof[6] = d*h - e*g; cof[7] = b*g - a*h; cof[8] = a*e - b*d;
         for (int i = 0; i < 9; i++) begin
            if (det == 0)
               el[i] = (i % 4 == 0) ? ONE_Q16 : '0;
            else
               el[i] = quotient_q16(cof[i], det, clipped);
         end
         r.inv_r0c0 = el[0]; r.inv_r0c1 = el[1]; r.inv_r0c2 = el[2];
         r.inv_r1c0 = el[3]; r.inv_r1c1 = el[4]; r.inv_r1c2 = el[5];
         r.inv_r2c0 = el[6]; r.inv_r2c1 = el[7]; r.inv_r2c2 = el[8];
         r.singular  = (det == 0);
         r.saturated = (det == 0) ? 1'b0 : clipped;
         pending.push_back(r);
      endfunction

      function void report(string field, longint want, longint got);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      endfunction

      // compare one delivered inverse with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.inv_r0c0 !== want.inv_r0c0) report("inv_r0c0", want.inv_r0c0, got.inv_r0c0);
         if (got.inv_r0c1 !== want.inv_r0c1) report("inv_r0c1", want.inv_r0c1, got.inv_r0c1);
         if (got.inv_r0c2 !== want.inv_r0c2) report("inv_r0c2", want.inv_r0c2, got.inv_r0c2);
         if (got.inv_r1c0 !== want.inv_r1c0) report("inv_r1c0", want.inv_r1c0, got.inv_r1c0);
         if (got.inv_r1c1 !== want.inv_r1c1) report("inv_r1c1", want.inv_r1c1, got.inv_r1c1);
         if (got.inv_r1c2 !== want.inv_r1c2) report("inv_r1c2", want.inv_r1c2, got.inv_r1c2);
         if (got.inv_r2c0 !== want.inv_r2c0) report("inv_r2c0", want.inv_r2c0, got.inv_r2c0);
         if (got.inv_r2c1 !== want.inv_r2c1) report("inv_r2c1", want.inv_r2c1, got.inv_r2c1);
         if (got.inv_r2c2 !== want.inv_r2c2) report("inv_r2c2", want.inv_r2c2, got.inv_r2c2);
         if (got.singular !== want.singular) report("singular", want.singular, got.singular);
         if (got.saturated !== want.saturated)
            report("saturated", want.saturated, got.saturated);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   inverse_board board;
   bit  quiet_phase;       // long stretch with no idling on either side
   bit  hold_rsp;          // receiver holding off to back up the pipeline
   bit  all_sent;

   matrix3_inverse dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // one element: mostly mixed values, with extremes and small ones thrown in
   function automatic logic [15:0] pick_element();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($signed($urandom_range(0, 16)) - 8);
         3:       return 16'h1000;
         default: return 16'($urandom);
      endcase
   endfunction

   // random matrix; some forced singular by copying or zeroing a row, some made diagonal
   function automatic req_type random_matrix();
      req_type m;
      m = req_type'({pick_element(), pick_element(), pick_element(),
                     pick_element(), pick_element(), pick_element(),
                     pick_element(), pick_element(), pick_element()});
      case ($urandom_range(0, 19))
         0: begin
            m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
         end
         1: begin
            m.in_r1c0 = 0; m.in_r1c1 = 0; m.in_r1c2 = 0;
         end
         2: begin
            // diagonal matrix, exercises exact and tiny determinants
            m.in_r0c1 = 0; m.in_r0c2 = 0; m.in_r1c0 = 0;
            m.in_r1c2 = 0; m.in_r2c0 = 0; m.in_r2c1 = 0;
         end
         default: ;
      endcase
      return m;
   endfunction

   // offer one matrix and hold it until the block takes it
   task automatic send_matrix(req_type m);
      req_data  <= m;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_matrix(m);
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   function automatic req_type diag_matrix(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2);
      req_type m;
      m = '0;
      m.in_r0c0 = v0; m.in_r1c1 = v1; m.in_r2c2 = v2;
      return m;
   endfunction

   task automatic run_directed();
      send_matrix(diag_matrix(16'h1000, 16'h1000, 16'h1000));   // identity
      send_matrix('0);                                          // all zero, singular
      send_matrix(req_type'({9{16'h7FFF}}));                    // equal rows
      send_matrix(req_type'({9{16'h8000}}));
      send_matrix(diag_matrix(16'h0001, 16'h0001, 16'h0001));   // tiny det
      send_matrix(diag_matrix(16'hFFFF, 16'h0001, 16'h0001));
      send_matrix(diag_matrix(16'h8000, 16'h8000, 16'h8000));   // most negative diagonal det
      send_matrix(diag_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_matrix(diag_matrix(16'h8000, 16'h7FFF, 16'h8000));
      send_matrix(diag_matrix(16'h2000, 16'hE000, 16'h0800));
      send_matrix(req_type'({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                             16'h8000, 16'h7FFF, 16'h8000, 16'h8000}));
      send_matrix(req_type'({16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000,
                             16'h0000, 16'h0000, 16'h0000, 16'h0001}));
      send_matrix(req_type'({16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'h0003,
                             16'h0000, 16'h0000, 16'h0000, 16'h0003}));  // inexact quotient, exercises rounding
      send_matrix(req_type'({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                             16'hAAAA, 16'h1234, 16'hFEDC, 16'h0F0F}));
      send_matrix(req_type'({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE}));
   endtask

   // sender: directed part, then random matrices with a quiet stretch in the middle
   initial begin
      board       = new();
      quiet_phase = 0;
      all_sent    = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int n = 0; n < 900; n++) begin
         quiet_phase = (n >= 300 && n < 450);
         send_matrix(random_matrix());
      end
      req_valid <= 1'b0;
      all_sent = 1;
   end

   // receiver: random stalls, and one long hold-off while the sender keeps going
   initial begin
      int held;
      rsp_ready = 1'b0;
      hold_rsp  = 0;
      held      = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (board.pending.size() > 20 && held == 0) begin
            hold_rsp = 1;
            held     = 1;
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end
         else begin
            rsp_ready <= quiet_phase || ($urandom_range(0, 99) >= 8);
            @(negedge clock);
         end
      end
   end

   // sample each delivered transaction at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_data);
   end

   // end of run: drain, let the pipeline settle, then give the verdict
   initial begin
      wait (all_sent);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

endmodule
